// ===== src/dnh_pkg.sv =====
// Package for the directory name hash block.
// Holds constants, the round-function helpers and the datapath control struct.
`default_nettype none
package dnh_pkg;
	localparam logic [31:0] MD4_A = 32'h67452301;
	localparam logic [31:0] MD4_B = 32'hefcdab89;
	localparam logic [31:0] MD4_C = 32'h98badcfe;
	localparam logic [31:0] MD4_D = 32'h10325476;
	localparam logic [31:0] K_R1 = 32'h5a827999;
	localparam logic [31:0] K_R2 = 32'h6ed9eba1;
	localparam logic [31:0] TEA_DELTA = 32'h9e3779b9;
	localparam logic [31:0] LEG_MUL = 32'd7152373;
	localparam logic [31:0] LEG_PREV0 = 32'h37abe8f9;
	localparam logic [31:0] LEG_CUR0 = 32'h12a3fe2d;
	localparam logic [31:0] LEG_FOLD = 32'h7fffffff;
	localparam logic [31:0] MAJ_BAD = 32'hfffffffe;
	localparam logic [31:0] MAJ_FIX = 32'hfffffffc;

	localparam logic [1:0] FAM_LEGACY = 2'd0;
	localparam logic [1:0] FAM_MD4 = 2'd1;
	localparam logic [1:0] FAM_TEA = 2'd2;

	localparam logic [2:0] REG_VERSION = 3'd0;
	localparam logic [2:0] REG_SEED0 = 3'd1;
	localparam logic [2:0] REG_SEED1 = 3'd2;
	localparam logic [2:0] REG_SEED2 = 3'd3;
	localparam logic [2:0] REG_SEED3 = 3'd4;

	// Chunk word index used by MD4 step s (0..23).
	function automatic logic [2:0] md4_word(input logic [4:0] s);
		logic [2:0] i;
		i = s[2:0];
		case (s[4:3])
			2'd0: md4_word = i;
			2'd1: md4_word = {i[1:0], 1'b0} + {2'b0, ~i[2]};
			default: md4_word = {i[0], i[2], i[1]} ^ 3'b011;
		endcase
	endfunction

	function automatic logic [4:0] md4_rot(input logic [4:0] s);
		logic [1:0] j;
		j = s[1:0];
		case (s[4:3])
			2'd0: md4_rot = (j == 2'd0) ? 5'd3 : (j == 2'd1) ? 5'd7 :
				(j == 2'd2) ? 5'd11 : 5'd19;
			2'd1: md4_rot = (j == 2'd0) ? 5'd3 : (j == 2'd1) ? 5'd5 :
				(j == 2'd2) ? 5'd9 : 5'd13;
			default: md4_rot = (j == 2'd0) ? 5'd3 : (j == 2'd1) ? 5'd9 :
				(j == 2'd2) ? 5'd11 : 5'd15;
		endcase
	endfunction

	function automatic logic [31:0] pad_of(input logic [7:0] r);
		pad_of = {r, r, r, r};
	endfunction

	typedef struct packed {
		logic       start;   // begin a chunk transform
		logic       is_md4;
	} xf_ctl_t;
endpackage
`default_nettype wire

// ===== src/dnh_xform.sv =====
// Iterative chunk transform: one MD4 step or one TEA half round per cycle.
// Depends on dnh_pkg for constants and step tables.
`default_nettype none
module dnh_xform (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire dnh_pkg::xf_ctl_t     ctl,
	input  wire logic [7:0][31:0]     chunk,
	input  wire logic [3:0][31:0]     hin,
	output logic [3:0][31:0]          hout,
	output logic                      done
);
	logic        busy_q;
	logic        md4_q;
	logic [4:0]  step_q;
	logic [3:0][31:0] w_q;
	logic [31:0] sum_q;
	logic [1:0]  t;
	logic [31:0] x, y, z, f, kc, add, rot, tb, tsum, tmix, tnew;
	logic [4:0]  rs;
	logic        last;

	always_comb begin
		unique case (step_q[1:0])
			2'd0: t = 2'd0;
			2'd1: t = 2'd3;
			2'd2: t = 2'd2;
			default: t = 2'd1;
		endcase
		x = w_q[t + 2'd1];
		y = w_q[t + 2'd2];
		z = w_q[t + 2'd3];
		case (step_q[4:3])
			2'd0: begin f = z ^ (x & (y ^ z)); kc = 32'd0; end
			2'd1: begin f = (x & y) + ((x ^ y) & z); kc = dnh_pkg::K_R1; end
			default: begin f = x ^ y ^ z; kc = dnh_pkg::K_R2; end
		endcase
		add = w_q[t] + f + chunk[dnh_pkg::md4_word(step_q)] + kc;
		rs = dnh_pkg::md4_rot(step_q);
		rot = (add << rs) | (add >> (6'd32 - {1'b0, rs}));
		// TEA: even step updates a from b, odd step updates b from a.
		tb = step_q[0] ? w_q[0] : w_q[1];
		tsum = step_q[0] ? sum_q : sum_q + dnh_pkg::TEA_DELTA;
		tmix = ((tb << 4) + (step_q[0] ? chunk[2] : chunk[0])) ^ (tb + tsum) ^
			((tb >> 5) + (step_q[0] ? chunk[3] : chunk[1]));
		tnew = (step_q[0] ? w_q[1] : w_q[0]) + tmix;
		last = md4_q ? (step_q == 5'd23) : (step_q == 5'd31);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			md4_q <= 1'b0;
			step_q <= '0;
		end else begin
			done <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				md4_q <= ctl.is_md4;
				step_q <= '0;
				w_q <= hin;
				sum_q <= '0;
			end else if (busy_q) begin
				if (md4_q) begin
					w_q[t] <= rot;
				end else if (step_q[0]) begin
					w_q[1] <= tnew;
				end else begin
					w_q[0] <= tnew;
					sum_q <= tsum;
				end
				step_q <= step_q + 5'd1;
				if (last) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_comb begin
		hout = hin;
		hout[0] = hin[0] + w_q[0];
		hout[1] = hin[1] + w_q[1];
		if (md4_q) begin
			hout[2] = hin[2] + w_q[2];
			hout[3] = hin[3] + w_q[3];
		end
	end
endmodule
`default_nettype wire

// ===== src/directory_name_hash_core.sv =====
// Top level of the directory name hash block: input sequencing, packing, legacy hash.
// Depends on dnh_pkg and dnh_xform.
//
//   channel   direction  handshake         payload
//   in        to block   in_valid/stall    name_byte, name_size, is_last
//   out       from block out_valid/stall   hash_major, hash_minor, status
//   cfg       to block   cfg_we            cfg_index, cfg_data
//
// A request passes through the idle and the fill state; a legacy byte adds the
// multiply state ahead of the fold. A full or final chunk adds the transform
// state around the shared MD4/TEA step unit. After a last mark each pad byte passes
// the fill state again (and the multiply state for legacy), and the result is loaded
// in the done state. Reset clears the control state; the result register
// holds while out_stall is high, and only a second finished name waits for it.
`default_nettype none
module directory_name_hash_core #(
	parameter int MAX_NAME_LENGTH = 255
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  name_byte,
	input  wire logic [7:0]  name_size,
	input  wire logic        is_last,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      hash_major,
	output logic [31:0]      hash_minor,
	output logic             status,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	localparam logic [7:0] MaxLen = 8'(MAX_NAME_LENGTH);

	typedef enum logic [2:0] {S_IDLE, S_LMUL, S_XF, S_FILL, S_DONE} state_t;

	state_t           state_q;
	logic [2:0]       ver_q, cur_ver_q;
	logic [3:0][31:0] seed_q;
	logic             busy_q;
	logic [7:0]       len_q, cons_q;
	logic [5:0]       cnt_q;
	logic [31:0]      pack_q, pd_q;
	logic [7:0][31:0] chunk_q;
	logic [3:0][31:0] h_q;
	logic [31:0]      lprev_q, lcur_q, prod_q;
	logic             last_q;
	dnh_pkg::xf_ctl_t xctl;
	logic [3:0][31:0] hout;
	logic             xdone;

	logic [1:0]  fam;
	logic [7:0]  l_eff, byte_v;
	logic [31:0] v32, lnx, pack_n;
	logic [5:0]  cap, cnt_n;
	logic        accept, take, chunk_end, xf_go;

	always_comb begin
		fam = (cur_ver_q >= 3'd3) ? 2'(cur_ver_q - 3'd3) : cur_ver_q[1:0];
		cap = (fam == dnh_pkg::FAM_MD4) ? 6'd32 : 6'd16;
		// prod_q holds the raw byte in the fill state, or zero for a pad byte.
		byte_v = prod_q[7:0];
		v32 = {{24{byte_v[7] & (cur_ver_q < 3'd3)}}, byte_v};
		lnx = lprev_q + (lcur_q ^ prod_q);
		if (lnx[31]) lnx = lnx - dnh_pkg::LEG_FOLD;
		pack_n = v32 + (pack_q << 8);
		cnt_n = cnt_q + 6'd1;
		accept = in_valid && !in_stall;
		l_eff = (name_size > MaxLen) ? MaxLen : name_size;
		take = cons_q < len_q;
		chunk_end = (cnt_n >= cap) || (cons_q + 8'd1 == len_q);
		xf_go = (state_q == S_FILL) && take && (cur_ver_q < 3'd6) &&
			(fam != dnh_pkg::FAM_LEGACY) && chunk_end;
	end

	assign in_stall = (state_q != S_IDLE);

	dnh_xform u_xf (
		.clk(clk), .arst_n(arst_n), .ctl(xctl), .chunk(chunk_q), .hin(h_q),
		.hout(hout), .done(xdone)
	);

	// Config, output handshake, byte consumption into packing state; all via next-state regs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ver_q <= 3'd1;
			seed_q <= '0;
			busy_q <= 1'b0;
			out_valid <= 1'b0;
			xctl <= '0;
			cur_ver_q <= '0;
			len_q <= '0;
			cons_q <= '0;
			cnt_q <= '0;
			last_q <= 1'b0;
		end else begin
			xctl.start <= xf_go;
			xctl.is_md4 <= (fam == dnh_pkg::FAM_MD4);
			if (state_q == S_DONE && (!out_valid || !out_stall)) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == dnh_pkg::REG_VERSION) ver_q <= cfg_data[2:0];
				else if (cfg_index <= dnh_pkg::REG_SEED3)
					seed_q[2'(cfg_index - dnh_pkg::REG_SEED0)] <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_q <= is_last;
						if (!busy_q) begin
							busy_q <= 1'b1;
							len_q <= l_eff;
							cur_ver_q <= ver_q;
							h_q <= (seed_q == '0) ? {dnh_pkg::MD4_D, dnh_pkg::MD4_C,
								dnh_pkg::MD4_B, dnh_pkg::MD4_A} : seed_q;
							lprev_q <= dnh_pkg::LEG_PREV0;
							lcur_q <= dnh_pkg::LEG_CUR0;
							cons_q <= '0;
							cnt_q <= '0;
							pack_q <= dnh_pkg::pad_of(l_eff);
							pd_q <= dnh_pkg::pad_of(l_eff);
							state_q <= S_FILL;
							prod_q <= {24'd0, name_byte};
						end else begin
							prod_q <= {24'd0, name_byte};
							state_q <= S_FILL;
						end
					end
				end
				S_FILL: begin
					if (!take) begin
						if (last_q) state_q <= S_DONE;
						else state_q <= S_IDLE;
					end else if (cur_ver_q >= 3'd6) begin
						cons_q <= cons_q + 8'd1;
						prod_q <= '0;
						if (!last_q) state_q <= S_IDLE;
					end else if (fam == dnh_pkg::FAM_LEGACY) begin
						prod_q <= v32 * dnh_pkg::LEG_MUL;
						state_q <= S_LMUL;
					end else begin
						cons_q <= cons_q + 8'd1;
						cnt_q <= cnt_n;
						prod_q <= '0;
						if (cnt_n[1:0] == 2'd0) begin
							chunk_q[3'(cnt_n[5:2] - 4'd1)] <= pack_n;
							pack_q <= pd_q;
						end else pack_q <= pack_n;
						if (chunk_end) begin
							for (int k = 0; k < 8; k++) begin
								if (k >= int'(cnt_n[5:2]) && k < int'(cap[5:2]))
									chunk_q[k] <= (k == int'(cnt_n[5:2]) &&
										cnt_n[1:0] != 2'd0) ? pack_n : pd_q;
							end
							state_q <= S_XF;
						end else if (!last_q) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_LMUL: begin
					lprev_q <= lcur_q;
					lcur_q <= lnx;
					cons_q <= cons_q + 8'd1;
					prod_q <= '0;
					state_q <= last_q ? S_FILL : S_IDLE;
				end
				S_XF: begin
					if (xdone) begin
						h_q <= hout;
						cnt_q <= '0;
						pd_q <= dnh_pkg::pad_of(len_q - cons_q);
						pack_q <= dnh_pkg::pad_of(len_q - cons_q);
						state_q <= last_q ? S_FILL : S_IDLE;
					end
				end
				S_DONE: begin
					if (!out_valid || !out_stall) begin
						busy_q <= 1'b0;
						state_q <= S_IDLE;
						status <= (cur_ver_q >= 3'd6);
						if (cur_ver_q >= 3'd6) begin
							hash_major <= '0;
							hash_minor <= '0;
						end else begin
							case (fam)
								dnh_pkg::FAM_LEGACY: begin
									hash_major <= ({lcur_q[30:0], 1'b0} == dnh_pkg::MAJ_BAD)
										? dnh_pkg::MAJ_FIX : {lcur_q[30:0], 1'b0};
									hash_minor <= '0;
								end
								dnh_pkg::FAM_MD4: begin
									hash_major <= ({h_q[1][31:1], 1'b0} == dnh_pkg::MAJ_BAD)
										? dnh_pkg::MAJ_FIX : {h_q[1][31:1], 1'b0};
									hash_minor <= h_q[2];
								end
								default: begin
									hash_major <= ({h_q[0][31:1], 1'b0} == dnh_pkg::MAJ_BAD)
										? dnh_pkg::MAJ_FIX : {h_q[0][31:1], 1'b0};
									hash_minor <= h_q[1];
								end
							endcase
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
